### rtl/nm_pkg.sv
// ---------------------------------------------------------------------------
// nm_pkg
// Shared constants for the normal matrix unit.
// ---------------------------------------------------------------------------
package nm_pkg;

    localparam int IN_WIDTH   = 16;
    localparam int OUT_WIDTH  = 32;
    localparam int QUOT_SHIFT = 28;
    localparam int FE_STAGES  = 4;
    localparam int N_ELEM     = 9;

endpackage

### rtl/nm_in_if.sv
// ---------------------------------------------------------------------------
// nm_in_if
// Input channel: one 3x3 matrix per transfer.
// ---------------------------------------------------------------------------
interface nm_in_if #(
    parameter int IW = nm_pkg::IN_WIDTH
);
    logic          valid;
    logic          ready;
    logic [IW-1:0] in_r0_c0;
    logic [IW-1:0] in_r0_c1;
    logic [IW-1:0] in_r0_c2;
    logic [IW-1:0] in_r1_c0;
    logic [IW-1:0] in_r1_c1;
    logic [IW-1:0] in_r1_c2;
    logic [IW-1:0] in_r2_c0;
    logic [IW-1:0] in_r2_c1;
    logic [IW-1:0] in_r2_c2;

    modport source (
        output valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
               in_r2_c0, in_r2_c1, in_r2_c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
               in_r2_c0, in_r2_c1, in_r2_c2,
        output ready
    );
endinterface

### rtl/nm_out_if.sv
// ---------------------------------------------------------------------------
// nm_out_if
// Output channel: one normal matrix and singular flag per transfer.
// ---------------------------------------------------------------------------
interface nm_out_if #(
    parameter int OW = nm_pkg::OUT_WIDTH
);
    logic          valid;
    logic          ready;
    logic [OW-1:0] out_r0_c0;
    logic [OW-1:0] out_r0_c1;
    logic [OW-1:0] out_r0_c2;
    logic [OW-1:0] out_r1_c0;
    logic [OW-1:0] out_r1_c1;
    logic [OW-1:0] out_r1_c2;
    logic [OW-1:0] out_r2_c0;
    logic [OW-1:0] out_r2_c1;
    logic [OW-1:0] out_r2_c2;
    logic          singular;

    modport source (
        output valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
               out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular,
        input  ready
    );
    modport sink (
        input  valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
               out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular,
        output ready
    );
endinterface

### rtl/nm_cof.sv
// ---------------------------------------------------------------------------
// nm_cof
// Cofactor and determinant front end, four pipeline stages.
// ---------------------------------------------------------------------------
module nm_cof #(
    parameter int IW = nm_pkg::IN_WIDTH,
    parameter int CW = 2 * IW + 1,
    parameter int DW = 3 * IW + 3
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [IW-1:0] i_a   [nm_pkg::N_ELEM],
    output logic signed [CW-1:0] o_cof [nm_pkg::N_ELEM],
    output logic signed [DW-1:0] o_det
);

    localparam int PW = 2 * IW;
    localparam int TW = IW + CW;

    logic signed [PW-1:0] r_pa  [nm_pkg::N_ELEM];
    logic signed [PW-1:0] r_pb  [nm_pkg::N_ELEM];
    logic signed [IW-1:0] r_a1  [3];
    logic signed [CW-1:0] r_c2  [nm_pkg::N_ELEM];
    logic signed [IW-1:0] r_a2  [3];
    logic signed [TW-1:0] r_dp  [3];
    logic signed [CW-1:0] r_c3  [nm_pkg::N_ELEM];
    logic signed [CW-1:0] r_c4  [nm_pkg::N_ELEM];
    logic signed [DW-1:0] r_det;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int E  = i * 3 + j;
            localparam int A1 = ((i + 1) % 3) * 3 + (j + 1) % 3;
            localparam int A2 = ((i + 2) % 3) * 3 + (j + 2) % 3;
            localparam int B1 = ((i + 1) % 3) * 3 + (j + 2) % 3;
            localparam int B2 = ((i + 2) % 3) * 3 + (j + 1) % 3;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[E] <= i_a[A1] * i_a[A2];
                    r_pb[E] <= i_a[B1] * i_a[B2];
                    r_c2[E] <= CW'(r_pa[E]) - CW'(r_pb[E]);
                    r_c3[E] <= r_c2[E];
                    r_c4[E] <= r_c3[E];
                end
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a1[j] <= i_a[j];
                r_a2[j] <= r_a1[j];
                r_dp[j] <= r_a2[j] * r_c2[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= DW'(r_dp[0]) + DW'(r_dp[1]) + DW'(r_dp[2]);
        end
    end

    assign o_cof = r_c4;
    assign o_det = r_det;

endmodule

### rtl/nm_div_lane.sv
// ---------------------------------------------------------------------------
// nm_div_lane
// One divider lane: pipelined restoring division, one quotient bit a stage
// after the first, with Q16.16 saturation.
// ---------------------------------------------------------------------------
module nm_div_lane #(
    parameter int CW = 33,
    parameter int DW = 51,
    parameter int OW = nm_pkg::OUT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_cof,
    input  logic signed [DW-1:0] i_det,
    output logic        [OW-1:0] o_q
);

    localparam int SH = nm_pkg::QUOT_SHIFT;
    localparam int NW = CW + SH;
    localparam int QW = OW;
    localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [CW-1:0] cmag;
    logic [DW-1:0] dmag;
    logic [XW-1:0] nmag;

    logic [XW-1:0] r_rem [QW];
    logic [DW-1:0] r_dv  [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    assign cmag = i_cof[CW-1] ? CW'(-i_cof) : CW'(i_cof);
    assign dmag = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
    assign nmag = XW'(cmag) << SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= nmag;
            r_dv[0]  <= dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_cof[CW-1] ^ i_det[DW-1];
            r_ovf[0] <= nmag >= (XW'(dmag) << QW);
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        localparam int K = QW - s;
        logic [XW-1:0] dsh;
        logic          ge;
        logic [QW-1:0] n_q;

        assign dsh = XW'(r_dv[s-1]) << K;
        assign ge  = r_rem[s-1] >= dsh;

        always_comb begin
            n_q    = r_q[s-1];
            n_q[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[s]  <= r_dv[s-1];
                r_q[s]   <= n_q;
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end

        if (s < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? r_rem[s-1] - dsh : r_rem[s-1];
                end
            end
        end
    end

    localparam logic [OW:0] MAG_HI = {2'b00, {(OW-1){1'b1}}};
    localparam logic [OW:0] MAG_LO = {2'b01, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] SAT_HI = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] SAT_LO = {1'b1, {(OW-1){1'b0}}};

    logic [OW:0] mag;
    assign mag = {1'b0, r_q[QW]};

    always_comb begin
        priority if (r_ovf[QW]) begin
            o_q = r_neg[QW] ? SAT_LO : SAT_HI;
        end else if (!r_neg[QW]) begin
            o_q = (mag > MAG_HI) ? SAT_HI : r_q[QW];
        end else begin
            o_q = (mag > MAG_LO) ? SAT_LO : OW'(-mag);
        end
    end

endmodule

### rtl/normal_matrix_3x3_unit.sv
// ---------------------------------------------------------------------------
// normal_matrix_3x3_unit
// Inverse-transpose (normal matrix) of a 3x3 Q4.12 matrix, Q16.16 results.
// ---------------------------------------------------------------------------
// Accepts one matrix per clock and returns one result per matrix, in order.
// Four front-end stages form the nine cofactors and the determinant, nine
// divider lanes each take OUT_WIDTH + 1 stages (one quotient bit per stage
// after the first), and an output register merges the lanes with the
// singular flag. A stalled output holds the whole pipeline; ready drops
// only while the output register is full and not taken.
module normal_matrix_3x3_unit #(
    parameter int IN_WIDTH  = nm_pkg::IN_WIDTH,
    parameter int OUT_WIDTH = nm_pkg::OUT_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    nm_in_if.sink   i_in,
    nm_out_if.source o_out
);

    localparam int NE  = nm_pkg::N_ELEM;
    localparam int CW  = 2 * IN_WIDTH + 1;
    localparam int DW  = 3 * IN_WIDTH + 3;
    localparam int DL  = OUT_WIDTH + 1;
    localparam int LAT = nm_pkg::FE_STAGES + DL;

    logic                        en;
    logic signed [IN_WIDTH-1:0]  a     [NE];
    logic signed [CW-1:0]        cof   [NE];
    logic signed [DW-1:0]        det;
    logic        [OUT_WIDTH-1:0] q     [NE];
    logic        [LAT-1:0]       r_vld;
    logic        [DL-1:0]        r_sng;
    logic        [OUT_WIDTH-1:0] r_out [NE];
    logic                        r_osng;
    logic                        r_ovld;

    assign en         = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    assign a[0] = i_in.in_r0_c0;
    assign a[1] = i_in.in_r0_c1;
    assign a[2] = i_in.in_r0_c2;
    assign a[3] = i_in.in_r1_c0;
    assign a[4] = i_in.in_r1_c1;
    assign a[5] = i_in.in_r1_c2;
    assign a[6] = i_in.in_r2_c0;
    assign a[7] = i_in.in_r2_c1;
    assign a[8] = i_in.in_r2_c2;

    nm_cof #(
        .IW (IN_WIDTH),
        .CW (CW),
        .DW (DW)
    ) u_cof (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (a),
        .o_cof (cof),
        .o_det (det)
    );

    for (genvar e = 0; e < NE; e++) begin : g_lane
        nm_div_lane #(
            .CW (CW),
            .DW (DW),
            .OW (OUT_WIDTH)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cof (cof[e]),
            .i_det (det),
            .o_q   (q[e])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_out[e] <= r_sng[DL-1] ? '0 : q[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sng  <= {r_sng[DL-2:0], det == '0};
            r_osng <= r_sng[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[LAT-2:0], i_in.valid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    assign o_out.valid     = r_ovld;
    assign o_out.singular  = r_osng;
    assign o_out.out_r0_c0 = r_out[0];
    assign o_out.out_r0_c1 = r_out[1];
    assign o_out.out_r0_c2 = r_out[2];
    assign o_out.out_r1_c0 = r_out[3];
    assign o_out.out_r1_c1 = r_out[4];
    assign o_out.out_r1_c2 = r_out[5];
    assign o_out.out_r2_c0 = r_out[6];
    assign o_out.out_r2_c1 = r_out[7];
    assign o_out.out_r2_c2 = r_out[8];

endmodule

### rtl/nm_checker.sv
// ---------------------------------------------------------------------------
// nm_checker
// Port-level checks for the normal matrix unit.
// ---------------------------------------------------------------------------
module nm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_singular,
    input logic i_any_nonzero
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_singular |-> !i_any_nonzero)
        else $error("singular result carries nonzero elements");

    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output can advance");

endmodule

bind normal_matrix_3x3_unit nm_checker u_nm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_singular    (o_out.singular),
    .i_any_nonzero (|{o_out.out_r0_c0, o_out.out_r0_c1, o_out.out_r0_c2,
                      o_out.out_r1_c0, o_out.out_r1_c1, o_out.out_r1_c2,
                      o_out.out_r2_c0, o_out.out_r2_c1, o_out.out_r2_c2})
);

### verif/normal_matrix_3x3_unit_tb.sv
// ---------------------------------------------------------------------------
// normal_matrix_3x3_unit_tb
// Self-checking regression for the normal matrix unit.
// ---------------------------------------------------------------------------
// Drives 3x3 Q4.12 matrices (directed corners, singular, saturating and
// random cases) with random gaps on both channels, predicts the exact
// cofactor/determinant quotient and compares each result in order.
module normal_matrix_3x3_unit_tb;

    typedef logic signed [nm_pkg::IN_WIDTH-1:0]  t_elem;
    typedef logic signed [nm_pkg::OUT_WIDTH-1:0] t_nelem;

    typedef struct {
        t_nelem m [nm_pkg::N_ELEM];
        logic   sing;
    } t_normal;

    class t_normal_scoreboard;
        t_normal pending [$];
        int      errors;
        int      singular_seen;
        int      checked;

        function new();
            errors = 0;
            singular_seen = 0;
            checked = 0;
        endfunction

        function void note_matrix(t_elem a [nm_pkg::N_ELEM]);
            longint x [3][3];
            longint c [3][3];
            longint det;
            longint q;
            longint hi;
            longint lo;
            t_normal r;
            hi = (longint'(1) <<< (nm_pkg::OUT_WIDTH - 1)) - 1;
            lo = -hi - 1;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    x[i][j] = longint'(a[i*3+j]);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    c[i][j] = x[(i+1)%3][(j+1)%3] * x[(i+2)%3][(j+2)%3]
                            - x[(i+1)%3][(j+2)%3] * x[(i+2)%3][(j+1)%3];
            det = x[0][0]*c[0][0] + x[0][1]*c[0][1] + x[0][2]*c[0][2];
            r.sing = (det == 0);
            for (int k = 0; k < nm_pkg::N_ELEM; k++) begin
                if (det == 0) begin
                    r.m[k] = '0;
                end else begin
                    q = (c[k/3][k%3] * (longint'(1) <<< nm_pkg::QUOT_SHIFT)) / det;
                    if (q > hi) q = hi;
                    if (q < lo) q = lo;
                    r.m[k] = t_nelem'(q);
                end
            end
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_normal got);
            t_normal w;
            if (pending.size() == 0) begin
                report("result with no matrix outstanding");
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.sing) singular_seen++;
            if (got.sing !== w.sing)
                report($sformatf("#%0d singular got %b want %b", checked, got.sing, w.sing));
            for (int k = 0; k < nm_pkg::N_ELEM; k++)
                if (got.m[k] !== w.m[k])
                    report($sformatf("#%0d elem %0d got %h want %h",
                                     checked, k, got.m[k], w.m[k]));
        endtask
    endclass

    localparam int LATENCY  = 4 + nm_pkg::OUT_WIDTH + 2;
    localparam int WD_LIMIT = 20000;
    localparam int N_RANDOM = 1400;

    logic i_clk;
    logic i_rst_n;
    nm_in_if  #(.IW(nm_pkg::IN_WIDTH))  in_ch ();
    nm_out_if #(.OW(nm_pkg::OUT_WIDTH)) out_ch ();

    normal_matrix_3x3_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_normal_scoreboard board;
    int  idle_cycles;
    int  sent;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    task automatic send_matrix(t_elem a [nm_pkg::N_ELEM]);
        in_ch.valid    <= 1'b1;
        in_ch.in_r0_c0 <= a[0];
        in_ch.in_r0_c1 <= a[1];
        in_ch.in_r0_c2 <= a[2];
        in_ch.in_r1_c0 <= a[3];
        in_ch.in_r1_c1 <= a[4];
        in_ch.in_r1_c2 <= a[5];
        in_ch.in_r2_c0 <= a[6];
        in_ch.in_r2_c1 <= a[7];
        in_ch.in_r2_c2 <= a[8];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_matrix(a);
        sent++;
    endtask

    task automatic hold_off();
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic t_elem rand_elem(int mode);
        case (mode)
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(8192) - 4096);
            2: return t_elem'($urandom_range(6) - 3);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return '0;
                    default: return 16'sh1000;
                endcase
            end
        endcase
    endfunction

    task automatic run_directed();
        t_elem a [nm_pkg::N_ELEM];
        for (int t = 0; t < 14; t++) begin
            for (int k = 0; k < nm_pkg::N_ELEM; k++) a[k] = '0;
            case (t)
                0: ;
                1: begin a[0] = 16'sh1000; a[4] = 16'sh1000; a[8] = 16'sh1000; end
                2: for (int k = 0; k < nm_pkg::N_ELEM; k++) a[k] = 16'sh7fff;
                3: for (int k = 0; k < nm_pkg::N_ELEM; k++) a[k] = 16'sh8000;
                4: begin a[0] = 16'sh0001; a[4] = 16'sh0001; a[8] = 16'sh0001; end
                5: begin a[0] = 16'sh8000; a[4] = 16'sh7fff; a[8] = 16'sh8000; end
                6: begin a[0] = 16'sh7fff; a[4] = 16'sh7fff; a[8] = 16'sh7fff; end
                7: begin a[0] = 16'sh0001; a[4] = 16'sh7fff; a[8] = 16'sh8000;
                         a[1] = 16'sh7fff; end
                8: begin a[1] = 16'sh1000; a[3] = 16'sh1000; a[8] = 16'shf000; end
                9: begin
                    for (int k = 0; k < 3; k++) begin
                        a[k] = t_elem'($urandom); a[k+3] = a[k]; a[k+6] = t_elem'($urandom);
                    end
                end
                10: begin a[2] = 16'sh8000; a[4] = 16'sh8000; a[6] = 16'sh8000; end
                11: for (int k = 0; k < nm_pkg::N_ELEM; k++)
                        a[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
                12: begin a[0] = 16'sh0003; a[4] = 16'sh0007; a[8] = 16'sh0005;
                          a[1] = 16'sh0002; end
                default: for (int k = 0; k < nm_pkg::N_ELEM; k++) a[k] = t_elem'($urandom);
            endcase
            send_matrix(a);
            hold_off();
        end
    endtask

    task automatic run_random();
        t_elem a [nm_pkg::N_ELEM];
        int mode;
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < nm_pkg::N_ELEM; k++) a[k] = rand_elem(mode);
            if ($urandom_range(9) == 0) begin
                for (int k = 0; k < 3; k++) a[6+k] = a[$urandom_range(1)*3+k];
            end
            send_matrix(a);
            if (n % 300 > 40) hold_off();
        end
        in_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_normal got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.m[0] = out_ch.out_r0_c0; got.m[1] = out_ch.out_r0_c1;
                got.m[2] = out_ch.out_r0_c2; got.m[3] = out_ch.out_r1_c0;
                got.m[4] = out_ch.out_r1_c1; got.m[5] = out_ch.out_r1_c2;
                got.m[6] = out_ch.out_r2_c0; got.m[7] = out_ch.out_r2_c1;
                got.m[8] = out_ch.out_r2_c2; got.sing = out_ch.singular;
                board.check_result(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int g;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            g = gap_len();
            if ($urandom_range(3) == 0) g = 0;
            out_ch.ready <= (g == 0);
            @(posedge i_clk);
            if (g > 1) begin
                repeat (g - 1) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        board = new();
        idle_cycles = 0;
        sent = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_r0_c0 = '0; in_ch.in_r0_c1 = '0; in_ch.in_r0_c2 = '0;
        in_ch.in_r1_c0 = '0; in_ch.in_r1_c1 = '0; in_ch.in_r1_c2 = '0;
        in_ch.in_r2_c0 = '0; in_ch.in_r2_c1 = '0; in_ch.in_r2_c2 = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d matrices, %0d results checked, %0d singular",
                 sent, board.checked, board.singular_seen);
        if (board.errors == 0)
            $display("normal_matrix_3x3_unit regression: pass");
        else
            $display("normal_matrix_3x3_unit regression: fail");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        while (idle_cycles < WD_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
        $display("normal_matrix_3x3_unit regression: fail");
        $finish;
    end
endmodule

### normal_matrix_3x3_unit.f
rtl/nm_pkg.sv
rtl/nm_in_if.sv
rtl/nm_out_if.sv
rtl/nm_cof.sv
rtl/nm_div_lane.sv
rtl/normal_matrix_3x3_unit.sv
rtl/nm_checker.sv
verif/normal_matrix_3x3_unit_tb.sv
